// File: sv/cle_pkg.sv
package cle_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int COUNT_W       = $clog2(LINE_CAPACITY);

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

endpackage

// File: sv/console_line_editor.sv
// Console line editor. Each accepted transfer is either a received console byte
// (action 0) or a read of one stored line byte (action 1). Printable bytes are
// stored and echoed, backspace echoes BS, space, BS, ESC skips the next two
// bytes, CR or LF echoes LF and then reports the line as complete; the byte after
// that starts a new line. An input transfer is taken and updates the line state
// at once; its results leave one per cycle from the output register unless the
// receiver stalls, so a printable byte or a read gives one result, a line end two
// and a backspace three. The next input is taken in the cycle its predecessor's
// last result leaves, so a stream of such items runs at one item per result.
// Read data comes from the line store's registered read port.
module console_line_editor
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [7:0]          char_in,
    input  logic [6:0]          read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [7:0]          data_byte,
    output logic [6:0]          line_length,
    output logic                last
);

    typedef enum logic [1:0]
    {
        ESC_NONE,
        ESC_SKIP2,
        ESC_SKIP1
    } esc_t;

    typedef enum logic [1:0]
    {
        SEQ_ECHO,
        SEQ_LINE,
        SEQ_BKSP,
        SEQ_READ
    } seq_t;

    localparam int CW = cle_pkg::COUNT_W;

    logic [7:0]    line_mem [cle_pkg::LINE_CAPACITY];
    logic [7:0]    rd_data_reg;

    logic [CW-1:0] count_reg, count_next;
    esc_t          esc_reg, esc_next;
    logic          closed_reg, closed_next;

    logic          s2_valid_reg;
    seq_t          s2_seq_reg;
    logic [1:0]    s2_pos_reg;
    logic [7:0]    s2_char_reg;
    logic [6:0]    s2_len_reg;
    logic          s2_rd_ok_reg;

    logic          in_xfer;
    logic          out_xfer;
    logic          s2_done;
    logic          is_char;
    logic          is_read;
    logic [CW-1:0] base_count;
    logic          printable;
    logic          do_store;
    logic          has_res;
    seq_t          res_seq;
    logic          rd_ok;
    logic          last_cur;

    assign is_char   = (action == cle_pkg::ACTION_CHAR) && (char_in != cle_pkg::CH_NUL);
    assign is_read   = (action == cle_pkg::ACTION_READ);
    assign base_count = closed_reg ? '0 : count_reg;
    assign printable = (char_in >= cle_pkg::CH_SPACE) && (char_in <= cle_pkg::CH_TILDE);
    assign rd_ok     = int'(read_index) < int'(count_reg);

    always_comb
    begin
        last_cur = 1'b1;
        unique case (s2_seq_reg)
            SEQ_LINE: last_cur = (s2_pos_reg == 2'd1);
            SEQ_BKSP: last_cur = (s2_pos_reg == 2'd2);
            default:  last_cur = 1'b1;
        endcase
    end

    assign out_valid = s2_valid_reg;
    assign out_xfer  = s2_valid_reg && !out_stall;
    assign s2_done   = out_xfer && last_cur;
    assign in_stall  = s2_valid_reg && !s2_done;
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        count_next  = count_reg;
        esc_next    = esc_reg;
        closed_next = closed_reg;
        do_store    = 1'b0;
        has_res     = 1'b0;
        res_seq     = SEQ_READ;
        if (is_read)
        begin
            has_res = 1'b1;
        end
        else if (is_char)
        begin
            count_next  = base_count;
            closed_next = 1'b0;
            priority if (char_in == cle_pkg::CH_LF || char_in == cle_pkg::CH_CR)
            begin
                esc_next    = ESC_NONE;
                closed_next = 1'b1;
                has_res     = 1'b1;
                res_seq     = SEQ_LINE;
            end
            else if (char_in == cle_pkg::CH_ESC)
            begin
                esc_next = (esc_reg != ESC_NONE) ? ESC_NONE : ESC_SKIP2;
            end
            else if (char_in == cle_pkg::CH_BS)
            begin
                if (esc_reg != ESC_NONE)
                begin
                    esc_next = ESC_NONE;
                end
                else if (base_count != '0)
                begin
                    count_next = base_count - CW'(1);
                    has_res    = 1'b1;
                    res_seq    = SEQ_BKSP;
                end
            end
            else if (esc_reg == ESC_SKIP2)
            begin
                esc_next = ESC_SKIP1;
            end
            else if (esc_reg != ESC_NONE)
            begin
                esc_next = ESC_NONE;
            end
            else if (printable && (base_count < CW'(cle_pkg::LINE_CAPACITY - 1)))
            begin
                do_store   = 1'b1;
                count_next = base_count + CW'(1);
                has_res    = 1'b1;
                res_seq    = SEQ_ECHO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && do_store)
        begin
            line_mem[base_count] <= char_in;
        end
        if (in_xfer && is_read)
        begin
            rd_data_reg <= line_mem[CW'(read_index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            esc_reg      <= ESC_NONE;
            closed_reg   <= 1'b1;
            s2_valid_reg <= 1'b0;
            s2_seq_reg   <= SEQ_ECHO;
            s2_pos_reg   <= 2'd0;
        end
        else
        begin
            if (in_xfer)
            begin
                count_reg  <= count_next;
                esc_reg    <= esc_next;
                closed_reg <= closed_next;
            end
            if (in_xfer && has_res)
            begin
                s2_valid_reg <= 1'b1;
                s2_seq_reg   <= res_seq;
                s2_pos_reg   <= 2'd0;
            end
            else if (s2_done)
            begin
                s2_valid_reg <= 1'b0;
            end
            else if (out_xfer)
            begin
                s2_pos_reg <= s2_pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && has_res)
        begin
            s2_char_reg  <= char_in;
            s2_len_reg   <= 7'(count_next);
            s2_rd_ok_reg <= rd_ok;
        end
    end

    always_comb
    begin
        kind      = cle_pkg::KIND_ECHO;
        data_byte = s2_char_reg;
        unique case (s2_seq_reg)
            SEQ_ECHO:
            begin
                kind      = cle_pkg::KIND_ECHO;
                data_byte = s2_char_reg;
            end
            SEQ_LINE:
            begin
                kind      = (s2_pos_reg == 2'd0) ? cle_pkg::KIND_ECHO : cle_pkg::KIND_DONE;
                data_byte = (s2_pos_reg == 2'd0) ? cle_pkg::CH_LF : cle_pkg::CH_NUL;
            end
            SEQ_BKSP:
            begin
                kind      = cle_pkg::KIND_ECHO;
                data_byte = (s2_pos_reg == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
            end
            SEQ_READ:
            begin
                kind      = cle_pkg::KIND_READ;
                data_byte = s2_rd_ok_reg ? rd_data_reg : cle_pkg::CH_NUL;
            end
        endcase
    end

    assign line_length = s2_len_reg;
    assign last        = last_cur;

endmodule

// File: sv/cle_checker.sv
module cle_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic       last
);

    // line complete follows its LF echo in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == cle_pkg::KIND_ECHO
            && data_byte == cle_pkg::CH_LF && !last
        |=> out_valid && kind == cle_pkg::KIND_DONE)
        else $error("line complete does not follow LF echo");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cle_pkg::KIND_DONE |-> last && data_byte == cle_pkg::CH_NUL)
        else $error("bad line complete result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cle_pkg::KIND_READ |-> last)
        else $error("read result not final");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(kind))
        else $error("stalled result changed");

endmodule

bind console_line_editor cle_checker u_cle_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last)
);

// File: test/console_line_checker.sv
`timescale 1ns / 100ps

module console_line_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       action,
    input  logic [7:0] char_in,
    input  logic [6:0] read_index,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic [6:0] line_length,
    input  logic       last,
    output int         error_count,
    output int         pending,
    output int         checked
);

    localparam logic [1:0] SKIP_NONE = 2'd0;
    localparam logic [1:0] SKIP_TWO  = 2'd1;
    localparam logic [1:0] SKIP_ONE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [6:0] line_length;
        logic       last;
    } console_reply_t;

    logic [7:0]     line_bytes [cle_pkg::LINE_CAPACITY];
    int             held;
    logic [1:0]     skip_phase;
    logic           line_done;
    console_reply_t reply_q [$];

    task automatic push_reply(input logic [1:0] k, input logic [7:0] d, input logic fin);
        console_reply_t r;
        r.kind        = k;
        r.data_byte   = d;
        r.line_length = 7'(held);
        r.last        = fin;
        reply_q.push_back(r);
    endtask

    task automatic edit_line(input logic act, input logic [7:0] ch, input logic [6:0] idx);
        logic [7:0] rd;
        if (act == cle_pkg::ACTION_READ) begin
            rd = 8'h00;
            if (int'(idx) < held && int'(idx) < cle_pkg::LINE_CAPACITY)
                rd = line_bytes[idx];
            push_reply(cle_pkg::KIND_READ, rd, 1'b1);
        end
        else if (ch != cle_pkg::CH_NUL) begin
            if (line_done) begin
                held      = 0;
                line_done = 1'b0;
            end
            if (ch == cle_pkg::CH_LF || ch == cle_pkg::CH_CR) begin
                skip_phase = SKIP_NONE;
                line_done  = 1'b1;
                push_reply(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, 1'b0);
                push_reply(cle_pkg::KIND_DONE, 8'h00, 1'b1);
            end
            else if (ch == cle_pkg::CH_ESC) begin
                skip_phase = (skip_phase != SKIP_NONE) ? SKIP_NONE : SKIP_TWO;
            end
            else if (ch == cle_pkg::CH_BS) begin
                if (skip_phase != SKIP_NONE)
                    skip_phase = SKIP_NONE;
                else if (held != 0) begin
                    held--;
                    push_reply(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 1'b0);
                    push_reply(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, 1'b0);
                    push_reply(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, 1'b1);
                end
            end
            else if (skip_phase == SKIP_TWO) begin
                skip_phase = SKIP_ONE;
            end
            else if (skip_phase != SKIP_NONE) begin
                skip_phase = SKIP_NONE;
            end
            else if (ch >= cle_pkg::CH_SPACE && ch <= cle_pkg::CH_TILDE &&
                     held < cle_pkg::LINE_CAPACITY - 1) begin
                line_bytes[held] = ch;
                held++;
                push_reply(cle_pkg::KIND_ECHO, ch, 1'b1);
            end
        end
    endtask

    task automatic check_reply();
        console_reply_t want;
        checked++;
        if (reply_q.size() == 0) begin
            if (error_count < 10)
                $display("%0t: unexpected reply kind %0d data %h len %0d last %b",
                         $time, kind, data_byte, line_length, last);
            error_count++;
        end
        else begin
            want = reply_q.pop_front();
            if (want.kind !== kind || want.data_byte !== data_byte ||
                want.line_length !== line_length || want.last !== last) begin
                if (error_count < 10) begin
                    $display("%0t: reply mismatch", $time);
                    $display("    expected kind %0d data %h len %0d last %b",
                             want.kind, want.data_byte, want.line_length, want.last);
                    $display("    actual   kind %0d data %h len %0d last %b",
                             kind, data_byte, line_length, last);
                end
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held        = 0;
            skip_phase  = SKIP_NONE;
            line_done   = 1'b1;
            reply_q.delete();
            error_count = 0;
            checked     = 0;
        end
        else begin
            if (out_valid && !out_stall)
                check_reply();
            if (in_valid && !in_stall)
                edit_line(action, char_in, read_index);
        end
        pending = reply_q.size();
    end

endmodule

// File: test/console_line_editor_tb.sv
`timescale 1ns / 100ps

module console_line_editor_tb;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 18;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       action;
    logic [7:0] char_in;
    logic [6:0] read_index;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [6:0] line_length;
    logic       last;

    int   error_count;
    int   pending;
    int   checked;
    int   accepted;
    int   cycle_count;
    logic calm;
    logic squeeze;

    console_line_editor dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .char_in     (char_in),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_length (line_length),
        .last        (last)
    );

    console_line_checker reply_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .char_in     (char_in),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_length (line_length),
        .last        (last),
        .error_count (error_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("console_line_editor_tb: done, errors");
        $finish;
    end

    // receiver: random stalls, quiet during calm, long hold-off on request
    initial
    begin
        int hold_count;
        hold_count = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (squeeze) begin
                out_stall = 1'b1;
                hold_count++;
                if (hold_count == HOLD_CYCLES) begin
                    squeeze    = 1'b0;
                    hold_count = 0;
                end
            end
            else begin
                out_stall = !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_item(input logic act, input logic [7:0] ch, input logic [6:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = act;
        char_in    = ch;
        read_index = idx;
        do
            @(posedge clk);
        while (in_stall);
        accepted++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(cle_pkg::ACTION_CHAR, ch, 7'($urandom));
    endtask

    task automatic send_read(input logic [6:0] idx);
        send_item(cle_pkg::ACTION_READ, 8'($urandom), idx);
    endtask

    task automatic type_line(input int keys);
        int pick;
        for (int k = 0; k < keys; k++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_char(8'($urandom_range(cle_pkg::CH_SPACE, cle_pkg::CH_TILDE)));
            end
            else if (pick < 68) begin
                send_char(cle_pkg::CH_BS);
            end
            else if (pick < 78) begin
                send_char(cle_pkg::CH_ESC);
                pick = $urandom_range(99);
                if (pick < 50)
                    send_char("[");
                else if (pick < 65)
                    send_char(cle_pkg::CH_ESC);
                else if (pick < 80)
                    send_char(cle_pkg::CH_BS);
                else if (pick < 90)
                    send_char(cle_pkg::CH_CR);
                else
                    send_char(8'($urandom));
                send_char(8'($urandom_range("A", "D")));
            end
            else if (pick < 91) begin
                if ($urandom_range(3) == 0)
                    send_read(7'($urandom));
                else
                    send_read(7'($urandom_range(24)));
            end
            else begin
                send_char(8'($urandom));
            end
        end
        pick = $urandom_range(9);
        if (pick < 5)
            send_char(cle_pkg::CH_CR);
        else if (pick < 9)
            send_char(cle_pkg::CH_LF);
    endtask

    initial
    begin
        int random_start;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = cle_pkg::ACTION_CHAR;
        char_in    = cle_pkg::CH_NUL;
        read_index = 7'd0;
        calm       = 1'b0;
        squeeze    = 1'b0;
        accepted   = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_read(7'd0);
        send_char(cle_pkg::CH_NUL);
        send_char(cle_pkg::CH_SPACE);
        send_char(cle_pkg::CH_TILDE);
        send_char("A");
        send_char(8'h7F);
        send_char(8'hFF);
        send_char(8'h1F);
        send_read(7'd0);
        send_read(7'd2);
        send_read(7'd3);
        send_read(7'h7F);
        send_char(cle_pkg::CH_BS);
        send_char(cle_pkg::CH_ESC);
        send_char("x");
        send_char("y");
        send_char(cle_pkg::CH_ESC);
        send_char(cle_pkg::CH_ESC);
        send_char(cle_pkg::CH_ESC);
        send_char(cle_pkg::CH_BS);
        send_char(cle_pkg::CH_ESC);
        send_char(cle_pkg::CH_CR);
        send_read(7'd1);
        send_char(cle_pkg::CH_BS);
        send_char(cle_pkg::CH_LF);
        send_char(cle_pkg::CH_NUL);

        // fill a line past capacity while the receiver holds off
        calm    = 1'b1;
        squeeze = 1'b1;
        for (int k = 0; k < cle_pkg::LINE_CAPACITY + 2; k++)
            send_char(8'($urandom_range(cle_pkg::CH_SPACE, cle_pkg::CH_TILDE)));
        send_read(7'd125);
        send_read(7'd126);
        send_read(7'd127);
        send_char(cle_pkg::CH_BS);
        send_read(7'd126);
        send_char(cle_pkg::CH_CR);
        calm = 1'b0;

        random_start = accepted;
        while (accepted - random_start < RANDOM_ITEMS) begin
            type_line($urandom_range(1, 14));
        end
        in_valid = 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("console_line_editor_tb: %0d transfers in, %0d replies checked, %0d cycles",
                 accepted, checked, cycle_count);
        if (error_count == 0 && pending == 0)
            $display("console_line_editor_tb: done, clean");
        else
            $display("console_line_editor_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
sv/cle_pkg.sv
sv/console_line_editor.sv
sv/cle_checker.sv
test/console_line_checker.sv
test/console_line_editor_tb.sv
